/* design/lfr_pkg.sv */
package lfr_pkg;

  // widths of the transaction fields
  localparam int OP_W    = 2;
  localparam int FRAME_W = 6;
  localparam int COUNT_W = 7;

  localparam int DEF_NUM_FRAMES = 64;

  // operation codes
  localparam logic [OP_W-1:0] OP_VICTIM = 2'd0;
  localparam logic [OP_W-1:0] OP_PIN    = 2'd1;
  localparam logic [OP_W-1:0] OP_UNPIN  = 2'd2;

  // one result transaction
  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] evictable_count;
  } res_t;

endpackage

/* design/lfr_ram.sv */
module lfr_ram #(
  parameter int DEPTH = lfr_pkg::DEF_NUM_FRAMES,
  parameter int WIDTH = 1,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/lru_frame_replacer.sv */
// lru frame replacer: keeps the evictable buffer frames as a doubly linked
// list in the order they became evictable. in_op selects victim (remove and
// return the oldest frame), pin (remove the frame if listed) or unpin (append
// the frame at the newest end if not listed); a frame at or above NUM_FRAMES
// and the unused op code are ignored. Every input transaction yields exactly
// one output transaction carrying found, victim_frame and the evictable count
// after the operation. An operation has a read step that fetches the frame's
// membership bit and both links from the synchronous memories, a step that
// rewrites the neighbor links and head/tail pointers, and a step that hands
// the result to the output register; a new transaction is taken only once the
// previous result has entered the output register. The output register lets
// the next transaction start while a result waits. After reset the membership
// memory is cleared one entry per cycle, holding in_stall high throughout.
module lru_frame_replacer #(
  parameter int NUM_FRAMES = lfr_pkg::DEF_NUM_FRAMES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfr_pkg::OP_W-1:0]    in_op,
  input  logic [lfr_pkg::FRAME_W-1:0] in_frame,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [lfr_pkg::FRAME_W-1:0] out_victim_frame,
  output logic [lfr_pkg::COUNT_W-1:0] out_evictable_count
);

  localparam int IW      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int XW      = IW + lfr_pkg::FRAME_W;
  // only frames the 6-bit port can name are ever listed
  localparam int CNT_MAX = (NUM_FRAMES < (1 << lfr_pkg::FRAME_W)) ?
                           NUM_FRAMES : (1 << lfr_pkg::FRAME_W);

  // sequencer states
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [IW-1:0]               clr_r, clr_nxt;
  logic [lfr_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [IW-1:0]               fidx_r, fidx_nxt;
  logic                        frange_r, frange_nxt;
  logic [IW-1:0]               newest_r, newest_nxt;
  logic [IW-1:0]               oldest_r, oldest_nxt;
  logic [lfr_pkg::COUNT_W-1:0] count_r, count_nxt;
  lfr_pkg::res_t               res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lfr_pkg::res_t               out_r, out_nxt;

  // memory ports
  logic          il_we, il_wdata, il_q;
  logic [IW-1:0] il_waddr;
  logic          nw_we, ol_we;
  logic [IW-1:0] nw_waddr, nw_wdata, nw_q;
  logic [IW-1:0] ol_waddr, ol_wdata, ol_q;
  logic [IW-1:0] rd_addr;

  logic [XW-1:0] in_fext;
  logic [IW-1:0] in_fidx;
  logic          in_frange;
  logic          accept;
  logic          do_detach, do_attach;
  logic [XW-1:0] victim_ext;

  // frame number mapped onto the memory index
  assign in_fext   = {{IW{1'b0}}, in_frame};
  assign in_fidx   = in_fext[IW-1:0];
  assign in_frange = in_fext < XW'(NUM_FRAMES);

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // victim reads the oldest entry, pin and unpin read the named frame
  assign rd_addr = (in_op == lfr_pkg::OP_VICTIM) ? oldest_r : in_fidx;

  // membership bit per frame
  lfr_ram #(.DEPTH(NUM_FRAMES), .WIDTH(1), .AW(IW)) u_in_list (
    .clk   (clk),
    .we    (il_we),
    .waddr (il_waddr),
    .wdata (il_wdata),
    .raddr (rd_addr),
    .rdata (il_q)
  );

  // link toward the newer neighbor
  lfr_ram #(.DEPTH(NUM_FRAMES), .WIDTH(IW), .AW(IW)) u_newer_link (
    .clk   (clk),
    .we    (nw_we),
    .waddr (nw_waddr),
    .wdata (nw_wdata),
    .raddr (rd_addr),
    .rdata (nw_q)
  );

  // link toward the older neighbor
  lfr_ram #(.DEPTH(NUM_FRAMES), .WIDTH(IW), .AW(IW)) u_older_link (
    .clk   (clk),
    .we    (ol_we),
    .waddr (ol_waddr),
    .wdata (ol_wdata),
    .raddr (rd_addr),
    .rdata (ol_q)
  );

  // decision on the data read for the latched transaction
  assign do_detach = ((op_r == lfr_pkg::OP_VICTIM) && (count_r != '0)) ||
                     ((op_r == lfr_pkg::OP_PIN) && frange_r && il_q);
  assign do_attach = (op_r == lfr_pkg::OP_UNPIN) && frange_r && !il_q;

  assign victim_ext = {{lfr_pkg::FRAME_W{1'b0}}, fidx_r};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    fidx_nxt      = fidx_r;
    frange_nxt    = frange_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    il_we    = 1'b0;
    il_waddr = fidx_r;
    il_wdata = 1'b0;
    nw_we    = 1'b0;
    nw_waddr = fidx_r;
    nw_wdata = fidx_r;
    ol_we    = 1'b0;
    ol_waddr = fidx_r;
    ol_wdata = fidx_r;

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        // sweep the membership bits to zero
        il_we    = 1'b1;
        il_waddr = clr_r;
        il_wdata = 1'b0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == IW'(NUM_FRAMES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          op_nxt     = in_op;
          fidx_nxt   = rd_addr;
          frange_nxt = (in_op == lfr_pkg::OP_VICTIM) ? 1'b1 : in_frange;
          state_nxt  = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_nxt.found           = 1'b0;
        res_nxt.victim_frame    = '0;
        if (do_detach) begin
          il_we    = 1'b1;
          il_wdata = 1'b0;
          if (count_r <= lfr_pkg::COUNT_W'(1)) begin
            // last member leaves, pointers go stale
            count_nxt = '0;
          end else begin
            count_nxt = count_r - 1'b1;
            if (fidx_r == oldest_r) begin
              oldest_nxt = nw_q;
            end else if (fidx_r == newest_r) begin
              newest_nxt = ol_q;
            end else begin
              // splice the neighbors together
              nw_we    = 1'b1;
              nw_waddr = ol_q;
              nw_wdata = nw_q;
              ol_we    = 1'b1;
              ol_waddr = nw_q;
              ol_wdata = ol_q;
            end
          end
          if (op_r == lfr_pkg::OP_VICTIM) begin
            res_nxt.found        = 1'b1;
            res_nxt.victim_frame = victim_ext[lfr_pkg::FRAME_W-1:0];
          end
        end else if (do_attach) begin
          il_we    = 1'b1;
          il_wdata = 1'b1;
          if (count_r == '0) begin
            oldest_nxt = fidx_r;
          end else begin
            ol_we    = 1'b1;
            ol_waddr = fidx_r;
            ol_wdata = newest_r;
            nw_we    = 1'b1;
            nw_waddr = newest_r;
            nw_wdata = fidx_r;
          end
          newest_nxt = fidx_r;
          count_nxt  = count_r + 1'b1;
        end
        res_nxt.evictable_count = count_nxt;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        // hand over once the output register is free or being taken
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction payload, no reset needed
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    fidx_r   <= fidx_nxt;
    frange_r <= frange_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_found           = out_r.found;
  assign out_victim_frame    = out_r.victim_frame;
  assign out_evictable_count = out_r.evictable_count;

  // count never exceeds the frames that can be named
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lfr_pkg::COUNT_W'(CNT_MAX))
    else $error("evictable count above frame limit");

  // a victim on a nonempty list removes exactly one member
  a_victim_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == lfr_pkg::OP_VICTIM && count_r != '0)
    |=> count_r == $past(count_r) - 1'b1)
    else $error("victim did not shrink the list by one");

  // unpin of a listed frame leaves the count alone
  a_unpin_member: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && op_r == lfr_pkg::OP_UNPIN && il_q)
    |=> $stable(count_r))
    else $error("unpin of member changed the count");

  // a new result only appears after the result step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the handover step");

endmodule
